// ===== rtl/core/irle_pkg.sv =====
`timescale 1ns / 1ps

package irle_pkg;

    // Sizes of the item fields and of the configuration port.
    localparam int unsigned BYTE_W        = 8;
    localparam int unsigned VALUE_W       = 64;
    localparam int unsigned CFG_IDX_W     = 1;
    localparam int unsigned CFG_DATA_W    = 1;
    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_VARINT_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SIGNED_MODE = 1'b1;

    // Decoder phases.
    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_DELTA   = 3'd1,
        PH_BASE    = 3'd2,
        PH_LITERAL = 3'd3,
        PH_EMIT    = 3'd4
    } t_phase;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_TAKEN   = 2'd0,
        ST_REFUSED = 2'd1,
        ST_VALUE   = 2'd2,
        ST_EMPTY   = 2'd3
    } t_status;

    // Kind of request carried by one input item.
    typedef enum logic {
        KIND_BYTE    = 1'b0,
        KIND_REQUEST = 1'b1
    } t_kind;

    // One classified request as it travels through the queue.
    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] data;
    } t_item;

    // Queue handshake seen from one side.
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_req;

endpackage

// ===== rtl/core/irle_front.sv =====
`timescale 1ns / 1ps

module irle_front
    import irle_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_cmd,
    input  logic [BYTE_W-1:0] i_byte,
    output t_req              o_req,
    input  logic              i_req_ready
);

    logic  r_valid;
    t_item r_item;
    logic  n_valid;
    t_item n_item;

    // Take a request whenever the holding stage is empty or drains this cycle.
    assign o_ready = !r_valid || i_req_ready;

    // Classify the incoming request and hold it for the queue.
    always_comb begin
        n_valid = r_valid;
        n_item  = r_item;
        if (r_valid && i_req_ready) begin
            n_valid = 1'b0;
        end
        if (i_valid && o_ready) begin
            n_valid   = 1'b1;
            n_item.kind = i_cmd ? KIND_REQUEST : KIND_BYTE;
            // A value request carries no byte.
            n_item.data = i_cmd ? '0 : i_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_item <= n_item;
    end

    assign o_req.valid = r_valid;
    assign o_req.item  = r_item;

endmodule

// ===== rtl/core/irle_queue.sv =====
`timescale 1ns / 1ps

module irle_queue
    import irle_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_req  i_req,
    output logic  o_ready,
    output t_req  o_req,
    input  logic  i_pop
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push;
    logic             pop;

    assign o_ready = (r_count != FULL_CNT);
    assign push    = i_req.valid && o_ready;
    assign pop     = i_pop && (r_count != '0);

    assign o_req.valid = (r_count != '0);
    assign o_req.item  = r_mem[r_rd_ptr];

    // Pointers wrap at the depth, which need not be a power of two.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_req.item;
        end
    end

endmodule

// ===== rtl/core/irle_back.sv =====
`timescale 1ns / 1ps

module irle_back
    import irle_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_req                  i_req,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output t_status               o_status,
    output logic [VALUE_W-1:0]    o_value
);

    // Configuration registers.
    logic r_varint_mode;
    logic r_signed_mode;

    // Decoder state.
    t_phase             r_phase,  n_phase;
    logic [7:0]         r_rem,    n_rem;
    logic               r_is_rep, n_is_rep;
    logic [VALUE_W-1:0] r_cur,    n_cur;
    logic [7:0]         r_delta,  n_delta;
    logic [VALUE_W-1:0] r_acc,    n_acc;
    logic [3:0]         r_idx,    n_idx;
    logic               r_vw,     n_vw;

    // Output register.
    logic               r_out_valid,  n_out_valid;
    t_status            r_out_status, n_out_status;
    logic [VALUE_W-1:0] r_out_value,  n_out_value;

    logic               fire;
    logic [7:0]         b;
    logic [7:0]         rem_dec;
    logic [5:0]         vshamt;
    logic [VALUE_W-1:0] asm_acc;
    logic [3:0]         asm_idx;
    logic               asm_done;
    logic [VALUE_W-1:0] asm_value;

    // Work on the queue head whenever the output register is free or being taken.
    assign fire    = i_req.valid && (!r_out_valid || i_ready);
    assign o_pop   = fire;
    assign b       = i_req.item.data;
    assign rem_dec = r_rem - 8'd1;
    // Only byte indexes up to nine shift a group in, so six bits cover the amount.
    assign vshamt  = 6'(r_idx) * 6'd7;

    // Value assembler: folds the current byte into the accumulator.
    always_comb begin
        asm_acc = r_acc;
        asm_idx = (r_idx != 4'd15) ? r_idx + 4'd1 : r_idx;
        if (r_varint_mode) begin
            if (r_idx <= 4'd9) begin
                asm_acc = r_acc | (VALUE_W'(b[6:0]) << vshamt);
            end
            asm_done = !b[7];
            if (r_signed_mode) begin
                asm_value = {1'b0, asm_acc[VALUE_W-1:1]} ^ {VALUE_W{asm_acc[0]}};
            end else begin
                asm_value = asm_acc;
            end
        end else begin
            if (!r_idx[3]) begin
                asm_acc = r_acc | (VALUE_W'(b) << {r_idx[2:0], 3'b000});
            end
            asm_done  = asm_idx[3];
            asm_value = asm_acc;
        end
    end

    // Next state and result for the request at the queue head.
    always_comb begin
        n_phase      = r_phase;
        n_rem        = r_rem;
        n_is_rep     = r_is_rep;
        n_cur        = r_cur;
        n_delta      = r_delta;
        n_acc        = r_acc;
        n_idx        = r_idx;
        n_vw         = r_vw;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_value  = r_out_value;

        if (fire) begin
            n_out_valid = 1'b1;
            n_out_value = '0;
            if (i_req.item.kind == KIND_REQUEST) begin
                if (r_phase == PH_EMIT) begin
                    // Next value of a repeat run.
                    n_out_status = ST_VALUE;
                    n_out_value  = r_cur;
                    n_cur        = r_cur + {{(VALUE_W-8){r_delta[7]}}, r_delta};
                    n_rem        = rem_dec;
                    if (rem_dec == 8'd0) begin
                        n_phase = PH_HEADER;
                    end
                end else if (r_vw) begin
                    // Hand over the assembled literal and start the next one.
                    n_out_status = ST_VALUE;
                    n_out_value  = r_cur;
                    n_vw         = 1'b0;
                    n_rem        = rem_dec;
                    if (rem_dec == 8'd0) begin
                        n_phase = PH_HEADER;
                    end else begin
                        n_phase = PH_LITERAL;
                        n_acc   = '0;
                        n_idx   = '0;
                    end
                end else begin
                    n_out_status = ST_EMPTY;
                end
            end else if (r_phase == PH_EMIT || r_vw) begin
                n_out_status = ST_REFUSED;
            end else begin
                n_out_status = ST_TAKEN;
                case (r_phase)
                    PH_HEADER: begin
                        if (!b[7]) begin
                            n_rem    = b + 8'd3;
                            n_is_rep = 1'b1;
                            n_phase  = PH_DELTA;
                        end else begin
                            n_rem    = 8'd0 - b;
                            n_is_rep = 1'b0;
                            n_phase  = PH_LITERAL;
                            n_acc    = '0;
                            n_idx    = '0;
                        end
                    end
                    PH_DELTA: begin
                        n_delta = b;
                        n_phase = PH_BASE;
                        n_acc   = '0;
                        n_idx   = '0;
                    end
                    PH_BASE: begin
                        n_acc = asm_acc;
                        n_idx = asm_idx;
                        if (asm_done) begin
                            n_cur   = asm_value;
                            n_phase = PH_EMIT;
                        end
                    end
                    default: begin
                        n_acc = asm_acc;
                        n_idx = asm_idx;
                        if (asm_done) begin
                            n_cur = asm_value;
                            n_vw  = 1'b1;
                        end
                    end
                endcase
            end
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // State, configuration and output registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_varint_mode <= 1'b1;
            r_signed_mode <= 1'b1;
            r_phase       <= PH_HEADER;
            r_rem         <= '0;
            r_is_rep      <= 1'b0;
            r_cur         <= '0;
            r_delta       <= '0;
            r_acc         <= '0;
            r_idx         <= '0;
            r_vw          <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_wr_en && i_cfg_idx == CFG_IDX_VARINT_MODE) begin
                r_varint_mode <= i_cfg_data[0];
            end
            if (i_cfg_wr_en && i_cfg_idx == CFG_IDX_SIGNED_MODE) begin
                r_signed_mode <= i_cfg_data[0];
            end
            r_phase     <= n_phase;
            r_rem       <= n_rem;
            r_is_rep    <= n_is_rep;
            r_cur       <= n_cur;
            r_delta     <= n_delta;
            r_acc       <= n_acc;
            r_idx       <= n_idx;
            r_vw        <= n_vw;
            r_out_valid <= n_out_valid;
        end
        r_out_status <= n_out_status;
        r_out_value  <= n_out_value;
    end

    assign o_valid  = r_out_valid;
    assign o_status = r_out_status;
    assign o_value  = r_out_value;

    // A repeat run being given out always has values left and is a repeat run.
    a_emit_has_values: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_EMIT) |-> (r_rem != 8'd0) && r_is_rep)
        else $error("repeat run emitting with no values left");

    // A waiting literal only exists inside a literal run.
    a_waiting_in_literal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vw |-> (r_phase == PH_LITERAL) && !r_is_rep)
        else $error("literal value waiting outside a literal run");

    // Only a given value carries a nonzero payload.
    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != ST_VALUE) |-> (r_out_value == '0))
        else $error("nonzero value with a non-value status");

    // A refused byte leaves the decoder state untouched.
    a_refuse_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && i_req.item.kind == KIND_BYTE && (r_phase == PH_EMIT || r_vw))
        |=> $stable(r_phase) && $stable(r_rem) && $stable(r_cur))
        else $error("refused byte changed the decoder state");

endmodule

// ===== rtl/core/integer_run_length_decoder_v1.sv =====
`timescale 1ns / 1ps
// Path: an accepted request goes through the front-end holding stage, the queue and
// the back-end output register. Throughput: one request per cycle while results
// are taken, set by the back end's single decode step; the queue absorbs short output stalls.
// Reset: synchronous, active low; clears the queue, the decoder state and the
// output valid flag, and sets both mode registers to 1.

module integer_run_length_decoder_v1
    import irle_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write port.
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // Request stream.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [7:0] stream_byte
    input  logic                  s_axis_tuser,   // [0] cmd
    // Result stream.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [63:0]           m_axis_tdata,   // [63:0] decoded_value
    output logic [1:0]            m_axis_tuser    // [1:0] status
);

    t_req    front_req;
    logic    queue_ready;
    t_req    queue_req;
    logic    queue_pop;
    t_status out_status;

    // Front end: accepts and classifies requests.
    irle_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_cmd       (s_axis_tuser),
        .i_byte      (s_axis_tdata),
        .o_req       (front_req),
        .i_req_ready (queue_ready)
    );

    // Queue between front and back end.
    irle_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (front_req),
        .o_ready (queue_ready),
        .o_req   (queue_req),
        .i_pop   (queue_pop)
    );

    // Back end: run-length decoder and output register.
    irle_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_req       (queue_req),
        .o_pop       (queue_pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_status    (out_status),
        .o_value     (m_axis_tdata)
    );

    assign m_axis_tuser = out_status;

endmodule
